// ===== design/bsc_pkg.sv =====
// Package for the bounded stack calculator: operation codes, payload structs,
// sequencer states and value limits. No dependencies.
package bsc_pkg;

  localparam int unsigned StackDepthDefault = 1024;
  localparam int unsigned ValWidth = 31;
  localparam logic signed [31:0] ValMax = 32'sd1000000000;
  localparam logic signed [31:0] ValMin = -32'sd1000000000;

  typedef enum logic [3:0] {
    FuncStart = 4'd0,
    FuncNum   = 4'd1,
    FuncPop   = 4'd2,
    FuncDup   = 4'd3,
    FuncSwp   = 4'd4,
    FuncInv   = 4'd5,
    FuncAdd   = 4'd6,
    FuncSub   = 4'd7,
    FuncMul   = 4'd8,
    FuncDiv   = 4'd9,
    FuncMod   = 4'd10,
    FuncEnd   = 4'd11
  } func_e;

  typedef struct packed {
    logic [3:0]  func;
    logic [29:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [30:0] result;
    logic               error;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StRdTop,
    StRdTopWait,
    StRdSec,
    StRdSecWait,
    StExec,
    StDivide,
    StDivDone,
    StWrite,
    StWrite2,
    StEnd,
    StOut
  } state_e;

endpackage

// ===== design/bounded_stack_calculator_unit.sv =====
// Bounded stack calculator top level: sequencer, stack memory, shared divider.
// Depends on bsc_pkg.
//
// START writes in StWrite, NUM and POP act in StExec; an ignored item stays in
// StIdle. DUP and INV read the top (StRdTop, StRdTopWait) and act in StExec; others
// also read the second (StRdSec, StRdSecWait); SWP then writes in StWrite2, DIV and
// MOD run 30 shift-subtract steps through one unit and end in StDivDone. A fault seen
// before the operands are read ends the transaction in StExec. END passes StEnd and
// StOut, waiting there while an earlier result is stalled. One transaction at a time.
// Reset clears the depth, the fault flag and the sequencer, but not the stack memory.
module bounded_stack_calculator_unit #(
  parameter int unsigned StackDepth = bsc_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bsc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bsc_pkg::out_item_t out_data_o
);
  import bsc_pkg::*;

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned DepW  = $clog2(StackDepth + 1);

  // Stack memory, one write and one registered read port.
  logic signed [30:0] mem_q [StackDepth];
  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic signed [30:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  state_e             state_q, state_d;
  state_e             exec_next;
  logic               loaded_q, loaded_d;  // operands have been read for this item
  logic [3:0]         func_q, func_d;
  logic [29:0]        val_q, val_d;
  logic [DepW-1:0]    dep_q, dep_d;
  logic               fault_q, fault_d;
  logic signed [30:0] a_q, a_d, b_q, b_d;       // a is second, b is top
  logic signed [31:0] res_q, res_d;
  out_item_t          out_q, out_d;
  logic               ovld_q, ovld_d;
  // Divider: restoring, one quotient bit per cycle on magnitudes.
  logic [29:0]        quo_q, quo_d;
  logic [30:0]        rem_q, rem_d;
  logic [4:0]         cnt_q, cnt_d;

  logic [DepW-1:0]    dep_m1, dep_m2;
  logic               full, val_big;
  logic [30:0]        mag_b;
  logic [30:0]        rem_sh;
  logic signed [62:0] prod;
  logic signed [31:0] sum;

  assign dep_m1 = dep_q - DepW'(1);
  assign dep_m2 = dep_q - DepW'(2);
  assign full = (dep_q >= DepW'(StackDepth));
  assign val_big = ({2'b00, val_q} > ValMax);
  assign mag_b = b_q[30] ? 31'(-b_q) : 31'(b_q);
  assign rem_sh = {rem_q[29:0], quo_q[29]};
  assign prod = 63'(a_q) * 63'(b_q);

  always_comb begin
    case (func_e'(func_q))
      FuncSub: sum = 32'(a_q) - 32'(b_q);
      FuncInv: sum = -32'(b_q);
      default: sum = 32'(a_q) + 32'(b_q);
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (func_e'(in_data_i.func))
            FuncStart: state_d = StWrite;
            FuncEnd:   state_d = StEnd;
            default: begin
              if (!fault_q && in_data_i.func <= FuncEnd) state_d = StExec;
            end
          endcase
        end
      end
      StRdTop:     state_d = StRdTopWait;
      StRdTopWait: state_d = (func_q inside {FuncDup, FuncInv}) ? StExec : StRdSec;
      StRdSec:     state_d = StRdSecWait;
      StRdSecWait: state_d = StExec;
      StExec:      state_d = StIdle;
      StDivide:    state_d = (cnt_q == 5'd0) ? StDivDone : StDivide;
      StDivDone:   state_d = StIdle;
      StWrite:     state_d = StIdle;
      StWrite2:    state_d = StIdle;
      StEnd:       state_d = StOut;
      StOut:       state_d = StIdle;
      default:     state_d = StIdle;
    endcase
    // Phase-specific overrides in StExec are resolved in the output block.
    if (state_q == StExec) state_d = exec_next;
    if (state_q == StOut && (ovld_q && out_stall_i)) state_d = StOut;
  end

  // Outputs and datapath.
  always_comb begin
    func_d = func_q;  val_d = val_q;  dep_d = dep_q;  fault_d = fault_q;
    a_d = a_q;  b_d = b_q;  res_d = res_q;  out_d = out_q;
    quo_d = quo_q;  rem_d = rem_q;  cnt_d = cnt_q;  loaded_d = loaded_q;
    ovld_d = ovld_q && out_stall_i;
    we = 1'b0;  waddr = '0;  wdata = '0;  raddr = dep_m1[AddrW-1:0];
    exec_next = StIdle;
    in_stall_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          func_d = in_data_i.func;
          val_d = in_data_i.value;
          loaded_d = 1'b0;
        end
      end
      StRdTop: raddr = dep_m1[AddrW-1:0];
      StRdTopWait: begin
        b_d = rdata_q;
        raddr = dep_m2[AddrW-1:0];
      end
      StRdSec: raddr = dep_m2[AddrW-1:0];
      StRdSecWait: begin
        a_d = rdata_q;
        loaded_d = 1'b1;
      end
      StExec: begin
        case (func_e'(func_q))
          FuncNum: begin
            if (full || val_big) begin
              fault_d = 1'b1;
            end else begin
              we = 1'b1;  waddr = dep_q[AddrW-1:0];  wdata = 31'(val_q);
              dep_d = dep_q + DepW'(1);
            end
          end
          FuncPop: begin
            if (dep_q == '0) fault_d = 1'b1;
            else dep_d = dep_m1;
          end
          FuncDup: begin
            if (dep_q == '0 || full) fault_d = 1'b1;
            else if (!loaded_q) begin
              loaded_d = 1'b1;
              exec_next = StRdTop;
            end else begin
              we = 1'b1;  waddr = dep_q[AddrW-1:0];  wdata = b_q;
              dep_d = dep_q + DepW'(1);
            end
          end
          FuncInv: begin
            if (dep_q == '0) fault_d = 1'b1;
            else if (!loaded_q) begin
              loaded_d = 1'b1;
              exec_next = StRdTop;
            end else begin
              we = 1'b1;  waddr = dep_m1[AddrW-1:0];  wdata = 31'(sum);
            end
          end
          default: begin
            if (dep_q < DepW'(2)) fault_d = 1'b1;
            else if (!loaded_q) begin
              exec_next = StRdTop;
            end else if (func_q == FuncSwp) begin
              we = 1'b1;  waddr = dep_m1[AddrW-1:0];  wdata = a_q;
              exec_next = StWrite2;
            end else if (func_q == FuncDiv || func_q == FuncMod) begin
              if (b_q == '0) begin
                fault_d = 1'b1;
              end else begin
                quo_d = a_q[30] ? 30'(-a_q) : 30'(a_q);
                rem_d = '0;
                cnt_d = 5'd29;
                exec_next = StDivide;
              end
            end else begin
              if (func_q == FuncMul) begin
                if (prod > 63'(ValMax) || prod < 63'(ValMin)) fault_d = 1'b1;
                else res_d = 32'(prod);
              end else begin
                if (sum > ValMax || sum < ValMin) fault_d = 1'b1;
                else res_d = sum;
              end
              if (!fault_d) begin
                we = 1'b1;  waddr = dep_m2[AddrW-1:0];  wdata = 31'(res_d);
                dep_d = dep_m1;
              end
            end
          end
        endcase
      end
      StDivide: begin
        cnt_d = cnt_q - 5'd1;
        if (rem_sh >= mag_b) begin
          rem_d = rem_sh - mag_b;
          quo_d = {quo_q[28:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[28:0], 1'b0};
        end
      end
      StDivDone: begin
        if (func_q == FuncDiv)
          res_d = (a_q[30] ^ b_q[30]) ? -32'(quo_q) : 32'(quo_q);
        else
          res_d = a_q[30] ? -32'(rem_q) : 32'(rem_q);
        // Quotient and remainder never exceed the dividend's magnitude,
        // so the bound is met whenever the operands are in range.
        if (res_d > ValMax) begin
          fault_d = 1'b1;
        end else begin
          we = 1'b1;  waddr = dep_m2[AddrW-1:0];  wdata = 31'(res_d);
          dep_d = dep_m1;
        end
      end
      StWrite: begin
        if (func_q == FuncStart) begin
          we = 1'b1;  waddr = '0;  wdata = 31'(val_q);
          dep_d = DepW'(1);
          fault_d = val_big;
        end
      end
      StWrite2: begin
        we = 1'b1;  waddr = dep_m2[AddrW-1:0];  wdata = b_q;
      end
      StEnd: raddr = '0;
      StOut: begin
        if (!(ovld_q && out_stall_i)) begin
          ovld_d = 1'b1;
          if (fault_q || dep_q != DepW'(1)) out_d = '{result: '0, error: 1'b1};
          else out_d = '{result: rdata_q, error: 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      dep_q    <= '0;
      fault_q  <= 1'b0;
      ovld_q   <= 1'b0;
      loaded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dep_q    <= dep_d;
      fault_q  <= fault_d;
      ovld_q   <= ovld_d;
      loaded_q <= loaded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;  val_q <= val_d;  a_q <= a_d;  b_q <= b_d;
    res_q <= res_d;  out_q <= out_d;  quo_q <= quo_d;  rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/bsc_checker.sv =====
// Port-level checker for the bounded stack calculator, with its bind.
// Depends on bsc_pkg.
module bsc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input bsc_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bsc_pkg::out_item_t out_data_o
);
  import bsc_pkg::*;

  // An accepted START transaction always blocks the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.func == FuncStart) |=> in_stall_o)
    else $error("not busy");

  // A faulted result carries zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |-> (out_data_o.result == '0))
    else $error("error with nonzero result");

  // A result stays while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");

endmodule

bind bounded_stack_calculator_unit bsc_checker u_bsc_checker (.*);

// ===== sim/bounded_stack_calculator_unit_tb.sv =====
// Testbench for the bounded stack calculator top level.
// Depends on bsc_pkg and bounded_stack_calculator_unit; a scoreboard class
// predicts each END transaction's result from its own copy of the stack.
`timescale 1ns / 1ps

module bounded_stack_calculator_unit_tb;
  import bsc_pkg::*;

  localparam int unsigned Depth = 16;
  localparam longint Limit = 1000000000;
  localparam logic [3:0] JunkFirst = 4'd12;
  localparam logic [3:0] JunkLast = 4'd15;

  // Keeps the calculator's stack, depth and fault flag, and a queue of the
  // END results that are still owed by the block.
  class calc_scoreboard;
    longint stack_mem[Depth];
    int unsigned depth;
    bit fault;
    out_item_t owed[$];
    int unsigned errors;

    function void note_input(in_item_t it);
      longint v;
      longint a;
      longint b;
      longint r;
      out_item_t o;
      v = longint'(it.value);
      if (it.func == FuncStart) begin
        stack_mem[0] = v;
        depth = 1;
        fault = (v > Limit);
        return;
      end
      if (it.func == FuncEnd) begin
        o.error = fault || depth != 1;
        o.result = o.error ? '0 : 31'(stack_mem[0]);
        owed.push_back(o);
        return;
      end
      if (it.func > FuncEnd || fault) return;
      case (it.func)
        FuncNum: begin
          if (depth >= Depth || v > Limit) fault = 1;
          else begin
            stack_mem[depth] = v;
            depth++;
          end
        end
        FuncPop: begin
          if (depth == 0) fault = 1;
          else depth--;
        end
        FuncDup: begin
          if (depth == 0 || depth >= Depth) fault = 1;
          else begin
            stack_mem[depth] = stack_mem[depth-1];
            depth++;
          end
        end
        FuncSwp: begin
          if (depth < 2) fault = 1;
          else begin
            r = stack_mem[depth-1];
            stack_mem[depth-1] = stack_mem[depth-2];
            stack_mem[depth-2] = r;
          end
        end
        FuncInv: begin
          if (depth == 0) fault = 1;
          else stack_mem[depth-1] = -stack_mem[depth-1];
        end
        default: begin
          if (depth < 2) begin
            fault = 1;
            return;
          end
          a = stack_mem[depth-2];
          b = stack_mem[depth-1];
          case (it.func)
            FuncAdd: r = a + b;
            FuncSub: r = a - b;
            FuncMul: r = a * b;
            FuncDiv: r = (b == 0) ? 0 : a / b;
            default: r = (b == 0) ? 0 : a % b;
          endcase
          // Division by zero and any result beyond the value bound both
          // abort the program without touching the stack.
          if (((it.func == FuncDiv || it.func == FuncMod) && b == 0)
              || r > Limit || r < -Limit) fault = 1;
          else begin
            stack_mem[depth-2] = r;
            depth--;
          end
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %0d error %0d", $time, got.result, got.error);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.result !== exp.result) begin
        $display("%0t: result expected %0d actual %0d", $time, exp.result, got.result);
        errors++;
      end
      if (got.error !== exp.error) begin
        $display("%0t: error expected %0d actual %0d", $time, exp.error, got.error);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  calc_scoreboard sb;
  bit quiet;
  int unsigned sent;

  bounded_stack_calculator_unit #(
    .StackDepth(Depth)
  ) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stall unless quiet, check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 18);
  end

  // Drives one transaction, after a random gap unless quiet, and holds it
  // until accepted; valid stays high so the next can follow without a gap.
  task automatic send(logic [3:0] f, logic [29:0] v);
    in_item_t it;
    it.func = f;
    it.value = v;
    if (!quiet && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // Fills the stack to its full depth, applies a closing operation, then END.
  task automatic fill_stack(logic [3:0] last_op);
    send(FuncStart, 30'd5);
    repeat (Depth - 1) send(FuncNum, 30'($urandom_range(0, 1000)));
    send(last_op, 30'd1);
    send(FuncEnd, '0);
  endtask

  task automatic random_program();
    int unsigned n;
    int unsigned d;
    int unsigned k;
    logic [3:0] f;
    logic [29:0] v;
    send(FuncStart, ($urandom_range(0, 19) == 0) ? 30'($urandom) :
                    30'($urandom_range(0, 1000)));
    d = 1;
    n = $urandom_range(2, 12);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 3) f = 4'($urandom_range(JunkFirst, JunkLast));
      else if (k < 6) f = 4'($urandom_range(FuncPop, FuncMod));
      else if (d < 2 || k < 35) f = (k % 4 == 0) ? FuncDup : FuncNum;
      else f = 4'($urandom_range(FuncPop, FuncMod));
      k = $urandom_range(0, 9);
      if (k < 6) v = 30'($urandom_range(0, 40));
      else if (k < 9) v = 30'($urandom_range(0, 1000000000));
      else v = 30'($urandom);
      send(f, v);
      if (f == FuncNum || f == FuncDup) d++;
      else if (f >= FuncAdd && f <= FuncMod || f == FuncPop) d = (d > 0) ? d - 1 : 0;
    end
    if ($urandom_range(0, 19) != 0) send(FuncEnd, 30'($urandom));
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: value extremes, each operation, faults and junk codes.
    send(FuncStart, 30'd1000000000); send(FuncEnd, '0);
    send(FuncStart, 30'd1000000001); send(FuncEnd, '0);
    send(FuncStart, 30'h3fffffff); send(FuncNum, 30'd0); send(FuncEnd, '0);
    send(FuncStart, 30'd1000000000); send(FuncNum, 30'd1); send(FuncAdd, '0);
    send(FuncEnd, '0);
    send(FuncStart, 30'd7); send(FuncInv, '0); send(FuncNum, 30'd2);
    send(FuncDup, '0); send(FuncPop, '0); send(FuncDiv, '0); send(FuncEnd, '0);
    send(FuncStart, 30'd7); send(FuncInv, '0); send(FuncNum, 30'd2);
    send(FuncSwp, '0); send(FuncMod, '0); send(FuncEnd, '0);
    send(FuncStart, 30'd9); send(FuncNum, 30'd0); send(FuncDiv, '0); send(FuncEnd, '0);
    send(FuncStart, 30'd9); send(FuncNum, 30'd0); send(FuncMod, '0); send(FuncEnd, '0);
    send(FuncStart, 30'd40000); send(FuncDup, '0); send(FuncMul, '0); send(FuncEnd, '0);
    send(FuncStart, 30'd3); send(FuncNum, 30'd8); send(FuncSub, '0);
    send(JunkLast, 30'd1); send(JunkFirst, 30'd1); send(FuncEnd, '0);
    send(FuncStart, 30'd1); send(FuncPop, '0); send(FuncPop, '0); send(FuncEnd, '0);
    send(FuncStart, 30'd1); send(FuncPop, '0); send(FuncDup, '0); send(FuncInv, '0);
    send(FuncEnd, '0);
    send(FuncStart, 30'd1); send(FuncSwp, '0); send(FuncEnd, '0);
    send(FuncStart, 30'd1); send(FuncNum, 30'd1); send(FuncEnd, '0);
    send(FuncStart, 30'd1); send(FuncNum, 30'h3fffffff); send(FuncEnd, '0);
    send(FuncEnd, '0);

    // Full stack: overflow by NUM and by DUP, and operations at full depth.
    quiet = 1'b1;
    fill_stack(FuncNum);
    fill_stack(FuncDup);
    fill_stack(FuncSwp);
    fill_stack(FuncAdd);
    quiet = 1'b0;

    // Hold off until every owed result has arrived.
    drain();

    // Random programs, with a stretch where neither side idles.
    while (sent < 600) begin
      quiet = (sent > 250 && sent < 350);
      random_program();
    end
    quiet = 1'b0;
    send(FuncEnd, '0);

    drain();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
